// ===== hw/rtl/rssi_trend_tracker_macros.svh =====
// ----------------------------------------------------------------------------
// RSSI trend tracker assertion macros
// Shared property templates for the tracker checks.
// ----------------------------------------------------------------------------
`ifndef RSSI_TREND_TRACKER_MACROS_SVH
`define RSSI_TREND_TRACKER_MACROS_SVH

// same-cycle implication
`define RTT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rssi_trend_tracker: check failed");

// next-cycle implication
`define RTT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rssi_trend_tracker: check failed");

`endif

// ===== hw/rtl/rtt_pkg.sv =====
// ----------------------------------------------------------------------------
// RSSI trend tracker package
// Trend codes, register indexes, reset values and shared structs.
// ----------------------------------------------------------------------------
package rtt_pkg;

  typedef enum logic [1:0] {
    TR_COLDER = 2'd0,
    TR_STEADY = 2'd1,
    TR_WARMER = 2'd2,
    TR_HERE   = 2'd3
  } trend_e;

  localparam int unsigned AddrW   = 48;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DivNumW = 15;
  localparam int unsigned DivDenW = 8;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_TARGET_ADDRESS = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_VALID   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RSSI_NEAR      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RSSI_FAR       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MOVE_THRESHOLD = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CONFIRM_COUNT  = 3'd5;

  localparam logic [7:0] NearReset    = 8'hD8;  // -40 dBm
  localparam logic [7:0] FarReset     = 8'h9C;  // -100 dBm
  localparam logic [4:0] MoveReset    = 5'd2;
  localparam logic [3:0] ConfirmReset = 4'd4;

  localparam logic [15:0] CountMax     = 16'hFFFF;
  localparam logic [7:0]  RunMax       = 8'd255;
  localparam logic [15:0] ConfSamples  = 16'd40;
  localparam logic [15:0] LockSamples  = 16'd8;
  localparam logic signed [9:0] BelowMargin = 10'sd12;
  localparam logic [9:0]  PenaltyMax   = 10'd40;
  localparam logic [6:0]  PctMax       = 7'd100;
  localparam logic signed [9:0] HereMargin  = 10'sd6;

  typedef struct packed {
    logic [AddrW-1:0] target_address;
    logic             target_valid;
    logic [7:0]       rssi_near;
    logic [7:0]       rssi_far;
    logic [4:0]       move_threshold;
    logic [3:0]       confirm_count;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] dividend;
    logic [DivDenW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/rssi_trend_tracker.sv =====
// ----------------------------------------------------------------------------
// RSSI trend tracker
// Follows the signal level of one selected transmitter and reports a trend.
// ----------------------------------------------------------------------------
// Usage:
//   Settings are written on the cfg channel (index, data); the user must write
//   them only while no observation is in flight, which the block does not enforce; cfg_ready_o is always high.
//   Observations enter on s_axis; each one yields exactly one verdict on
//   m_axis, matched or not. Only a matching observation moves the averages,
//   peak, sample count and trend.
//   After the input transfer the block steps through update, trend, divider start,
//   divide and output; the input is ready again once the verdict is loaded, so one
//   item ends before the next is taken. The divide uses the 15-step serial divider.
//   The output register holds a verdict while the next observation is taken;
//   if the receiver stalls, the block holds the finished item until the
//   output register frees up and takes no input meanwhile.
//   Reset clears all tracking state: no samples, steady trend, peak -128,
//   and loads the default settings (no target selected).
// ----------------------------------------------------------------------------
`include "rssi_trend_tracker_macros.svh"

module rssi_trend_tracker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // tdata: source_address[47:0], signal_level[55:48]
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [55:0]                 s_axis_tdata,
  // tdata: matched[0], listening[1], trend[3:2], level_now[11:4],
  //        level_smoothed[19:12], level_peak[27:20], sample_total[43:28],
  //        closeness[50:44], confidence[57:51], locked[58]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [63:0]                 m_axis_tdata,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rtt_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rtt_pkg::AddrW-1:0]   cfg_data_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UPD   = 3'd1;
  localparam logic [2:0] S_TREND = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  rtt_pkg::cfg_t     cfg;
  rtt_pkg::div_req_t div_req;
  rtt_pkg::div_rsp_t div_rsp;

  logic [2:0]            state_d, state_q;
  logic                  match_d, match_q;
  logic [7:0]            level_d, level_q;
  logic signed [15:0]    fast_d, fast_q;
  logic signed [15:0]    slow_d, slow_q;
  logic signed [7:0]     peak_d, peak_q;
  logic signed [7:0]     last_d, last_q;
  logic [15:0]           count_d, count_q;
  rtt_pkg::trend_e       committed_d, committed_q;
  rtt_pkg::trend_e       pending_d, pending_q;
  logic [7:0]            run_d, run_q;
  logic signed [7:0]     smooth_d, smooth_q;
  logic signed [15:0]    num_d, num_q;
  logic signed [8:0]     span_d, span_q;
  logic                  m_valid_d, m_valid_q;
  logic [63:0]           m_data_d, m_data_q;

  // average update
  logic signed [15:0]    r_val;
  logic signed [16:0]    fast_diff, slow_diff;
  logic signed [16:0]    fast_sum, slow_sum;

  // trend evaluation
  logic signed [16:0]    avg_gap_raw;
  logic signed [9:0]     gap;
  logic signed [9:0]     smooth_w;
  logic signed [9:0]     mv_s, neg_mv, near_lim;
  rtt_pkg::trend_e       cand;
  logic [7:0]            run_inc;
  logic signed [15:0]    sdiff;

  // verdict
  logic [6:0]            clo;
  logic [7:0]            base_x5;
  logic [6:0]            conf_base;
  logic signed [9:0]     below;
  logic [9:0]            excess;
  logic [9:0]            pen3;
  logic [6:0]            pen;
  logic [6:0]            conf;
  logic signed [7:0]     smooth_clamped;
  logic                  out_free;
  logic [63:0]           verdict;

  rtt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rtt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = (state_q == S_IDLE);

  // ---- average update datapath ----
  assign r_val     = $signed({level_q, 8'h00});
  assign fast_diff = $signed({r_val[15], r_val}) - $signed({fast_q[15], fast_q});
  assign slow_diff = $signed({r_val[15], r_val}) - $signed({slow_q[15], slow_q});
  assign fast_sum  = $signed({fast_q[15], fast_q}) + (fast_diff >>> 2);
  assign slow_sum  = $signed({slow_q[15], slow_q}) + (slow_diff >>> 4);

  // ---- trend datapath: quotients by 256 truncate toward zero ----
  assign avg_gap_raw = $signed({fast_q[15], fast_q}) - $signed({slow_q[15], slow_q});

  always_comb begin
    gap = $signed({avg_gap_raw[16], avg_gap_raw[16:8]});
    if (avg_gap_raw[16] && (avg_gap_raw[7:0] != 8'h00)) begin
      gap = gap + 10'sd1;
    end
    smooth_w = $signed({{2{fast_q[15]}}, fast_q[15:8]});
    if (fast_q[15] && (fast_q[7:0] != 8'h00)) begin
      smooth_w = smooth_w + 10'sd1;
    end
  end

  assign mv_s     = $signed({5'b0, cfg.move_threshold});
  assign neg_mv   = -mv_s;
  assign near_lim = $signed({{2{cfg.rssi_near[7]}}, cfg.rssi_near}) - rtt_pkg::HereMargin;

  always_comb begin
    priority if ((smooth_w >= near_lim) && (gap > neg_mv)) begin
      cand = rtt_pkg::TR_HERE;
    end else if (gap >= mv_s) begin
      cand = rtt_pkg::TR_WARMER;
    end else if (gap <= neg_mv) begin
      cand = rtt_pkg::TR_COLDER;
    end else begin
      cand = rtt_pkg::TR_STEADY;
    end
  end

  assign run_inc = (run_q == rtt_pkg::RunMax) ? run_q : run_q + 8'd1;
  assign sdiff   = $signed({{6{smooth_w[9]}}, smooth_w})
                 - $signed({{8{cfg.rssi_far[7]}}, cfg.rssi_far});

  // ---- verdict datapath ----
  always_comb begin
    clo = '0;
    if ((span_q > 9'sd0) && (num_q > 16'sd0)) begin
      clo = (div_rsp.quotient > 15'(rtt_pkg::PctMax)) ? rtt_pkg::PctMax
                                                       : div_rsp.quotient[6:0];
    end
  end

  // samples * 100 / 40 = samples * 5 / 2 below 40 samples
  assign base_x5   = {count_q[5:0], 2'b00} + {2'b00, count_q[5:0]};
  assign conf_base = (count_q < rtt_pkg::ConfSamples) ? base_x5[7:1] : rtt_pkg::PctMax;
  assign below     = $signed({{2{peak_q[7]}}, peak_q}) - $signed({{2{smooth_q[7]}}, smooth_q});
  assign excess    = 10'(below - rtt_pkg::BelowMargin);
  assign pen3      = {excess[8:0], 1'b0} + excess;

  always_comb begin
    pen = '0;
    if (below > rtt_pkg::BelowMargin) begin
      pen = (pen3 > rtt_pkg::PenaltyMax) ? 7'(rtt_pkg::PenaltyMax) : pen3[6:0];
    end
    conf = (conf_base > pen) ? conf_base - pen : 7'd0;
  end

  assign smooth_clamped = (smooth_q > 8'sd0) ? 8'sd0 : smooth_q;

  always_comb begin
    if (count_q == '0) begin
      verdict = {60'd0, rtt_pkg::TR_STEADY, 1'b1, match_q};
    end else begin
      verdict = {5'd0,
                 (count_q >= rtt_pkg::LockSamples),
                 conf,
                 clo,
                 count_q,
                 peak_q,
                 smooth_clamped,
                 last_q,
                 committed_q,
                 1'b0,
                 match_q};
    end
  end

  assign out_free = !m_valid_q || m_axis_tready;

  // ---- sequencer ----
  always_comb begin
    state_d     = state_q;
    match_d     = match_q;
    level_d     = level_q;
    fast_d      = fast_q;
    slow_d      = slow_q;
    peak_d      = peak_q;
    last_d      = last_q;
    count_d     = count_q;
    committed_d = committed_q;
    pending_d   = pending_q;
    run_d       = run_q;
    smooth_d    = smooth_q;
    num_d       = num_q;
    span_d      = span_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_data_d    = m_data_q;

    div_req.start    = (state_q == S_START);
    div_req.dividend = num_q[14:0];
    div_req.divisor  = span_q[7:0];

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          match_d = cfg.target_valid && (s_axis_tdata[47:0] == cfg.target_address);
          level_d = s_axis_tdata[55:48];
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (match_q) begin
          if (count_q == '0) begin
            fast_d = r_val;
            slow_d = r_val;
          end else begin
            fast_d = fast_sum[15:0];
            slow_d = slow_sum[15:0];
          end
          last_d = $signed(level_q);
          if ($signed(level_q) > peak_q) begin
            peak_d = $signed(level_q);
          end
          if (count_q != rtt_pkg::CountMax) begin
            count_d = count_q + 16'd1;
          end
        end
        state_d = S_TREND;
      end
      S_TREND: begin
        if (match_q) begin
          if (cand == committed_q) begin
            pending_d = cand;
            run_d     = '0;
          end else if (cand == pending_q) begin
            run_d = run_inc;
            if ((cand == rtt_pkg::TR_STEADY) || (run_inc >= {4'b0, cfg.confirm_count})) begin
              committed_d = cand;
              run_d       = '0;
            end
          end else begin
            pending_d = cand;
            run_d     = 8'd1;
            if (cand == rtt_pkg::TR_STEADY) begin
              committed_d = rtt_pkg::TR_STEADY;
            end
          end
        end
        smooth_d = smooth_w[7:0];
        num_d    = sdiff * 16'sd100;
        span_d   = $signed({cfg.rssi_near[7], cfg.rssi_near})
                 - $signed({cfg.rssi_far[7], cfg.rssi_far});
        state_d  = S_START;
      end
      S_START: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = verdict;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fast_q      <= '0;
      slow_q      <= '0;
      peak_q      <= -8'sd128;
      last_q      <= '0;
      count_q     <= '0;
      committed_q <= rtt_pkg::TR_STEADY;
      pending_q   <= rtt_pkg::TR_STEADY;
      run_q       <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      fast_q      <= fast_d;
      slow_q      <= slow_d;
      peak_q      <= peak_d;
      last_q      <= last_d;
      count_q     <= count_d;
      committed_q <= committed_d;
      pending_q   <= pending_d;
      run_q       <= run_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_q  <= match_d;
    level_q  <= level_d;
    smooth_q <= smooth_d;
    num_q    <= num_d;
    span_q   <= span_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // ---- checks ----
  `RTT_ASSERT_IMPL(a_div_done_in_wait, clk_i, rst_ni, div_rsp.done, state_q == S_DIV)
  `RTT_ASSERT_IMPL(a_count_steps_by_one, clk_i, rst_ni, count_q != $past(count_q), count_q == $past(count_q) + 16'd1)
  `RTT_ASSERT_IMPL(a_commit_in_trend_step, clk_i, rst_ni, committed_q != $past(committed_q), $past(state_q) == S_TREND)
  `RTT_ASSERT_NEXT(a_transfer_starts_update, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, state_q == S_UPD)

endmodule

// ===== hw/rtl/rtt_cfg.sv =====
// ----------------------------------------------------------------------------
// RSSI trend tracker configuration registers
// Indexed write port into the tracker's settings.
// ----------------------------------------------------------------------------
module rtt_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rtt_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rtt_pkg::AddrW-1:0]   cfg_data_i,
  output rtt_pkg::cfg_t               cfg_o
);

  rtt_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rtt_pkg::CFG_TARGET_ADDRESS: cfg_d.target_address = cfg_data_i;
        rtt_pkg::CFG_TARGET_VALID:   cfg_d.target_valid   = cfg_data_i[0];
        rtt_pkg::CFG_RSSI_NEAR:      cfg_d.rssi_near      = cfg_data_i[7:0];
        rtt_pkg::CFG_RSSI_FAR:       cfg_d.rssi_far       = cfg_data_i[7:0];
        rtt_pkg::CFG_MOVE_THRESHOLD: cfg_d.move_threshold = cfg_data_i[4:0];
        rtt_pkg::CFG_CONFIRM_COUNT:  cfg_d.confirm_count  = cfg_data_i[3:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_address <= '0;
      cfg_q.target_valid   <= 1'b0;
      cfg_q.rssi_near      <= rtt_pkg::NearReset;
      cfg_q.rssi_far       <= rtt_pkg::FarReset;
      cfg_q.move_threshold <= rtt_pkg::MoveReset;
      cfg_q.confirm_count  <= rtt_pkg::ConfirmReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/rtt_div.sv =====
// ----------------------------------------------------------------------------
// RSSI trend tracker serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rtt_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rtt_pkg::div_req_t req_i,
  output rtt_pkg::div_rsp_t rsp_o
);

  localparam int unsigned NumW = rtt_pkg::DivNumW;
  localparam int unsigned DenW = rtt_pkg::DivDenW;
  localparam int unsigned CntW = $clog2(NumW);

  logic            busy_d, busy_q;
  logic            done_d, done_q;
  logic [CntW-1:0] cnt_d, cnt_q;
  logic [DenW-1:0] rem_d, rem_q;
  logic [DenW-1:0] den_d, den_q;
  logic [NumW-1:0] quo_d, quo_q;
  logic [DenW:0]   trial;
  logic [DenW:0]   trial_sub;
  logic            fits;

  // partial remainder stays below the divisor, so one extra bit suffices
  assign trial     = {rem_q, quo_q[NumW-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign fits      = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW - 1);
      rem_d  = '0;
      den_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      rem_d = fits ? trial_sub[DenW-1:0] : trial[DenW-1:0];
      quo_d = {quo_q[NumW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== sim/tb_rssi_trend_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSSI trend tracker testbench
// Feeds address/level observations through the stream ports under random
// source gaps and sink stalls, rewrites the settings between phases, and
// compares every verdict field with an in-bench tracker model or a directed expected verdict.
// ----------------------------------------------------------------------------
module tb_rssi_trend_tracker;

  localparam int unsigned MaxCycles  = 1_000_000;
  localparam int unsigned HoldCycles = 600;
  localparam int unsigned NumPhases  = 7;
  localparam int unsigned TailCycles = 40;
  localparam logic [47:0] AllOnes    = 48'hFFFF_FFFF_FFFF;

  // verdict word, lowest field last
  typedef struct packed {
    logic [4:0]      pad;
    logic            locked;
    logic [6:0]      confidence;
    logic [6:0]      closeness;
    logic [15:0]     sample_total;
    logic [7:0]      level_peak;
    logic [7:0]      level_smoothed;
    logic [7:0]      level_now;
    rtt_pkg::trend_e trend;
    logic            listening;
    logic            hit;
  } verdict_t;

  typedef enum logic {ROW_OBS, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                   kind;
    logic [rtt_pkg::CfgIdxW-1:0] idx;
    logic [47:0]                 word;   // address, or register data
    logic [7:0]                  level;
    bit                          typed;
    verdict_t                    want;
  } stim_row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [55:0]                 s_axis_tdata;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  logic [63:0]                 m_axis_tdata;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [rtt_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [rtt_pkg::AddrW-1:0]   cfg_data_i;

  // tracker model: settings and state
  logic [47:0]     tgt_addr    = '0;
  logic            tgt_en      = 1'b0;
  logic [7:0]      near_cfg    = rtt_pkg::NearReset;
  logic [7:0]      far_cfg     = rtt_pkg::FarReset;
  logic [4:0]      move_cfg    = rtt_pkg::MoveReset;
  logic [3:0]      confirm_cfg = rtt_pkg::ConfirmReset;
  int              avg_fast    = 0;
  int              avg_slow    = 0;
  int              peak_dbm    = -128;
  int              last_dbm    = 0;
  int              sample_cnt  = 0;
  rtt_pkg::trend_e trend_now   = rtt_pkg::TR_STEADY;
  rtt_pkg::trend_e trend_next  = rtt_pkg::TR_STEADY;
  int              pending_len = 0;

  verdict_t    verdict_q[$];
  stim_row_t   dir_rows[$];

  int unsigned cycle_cnt   = 0;
  int unsigned err_cnt     = 0;
  int unsigned verdict_cnt = 0;
  int unsigned obs_sent    = 0;
  int unsigned hit_cnt     = 0;
  int unsigned phase_cnt   = 0;
  bit          tx_steady   = 1'b0;
  bit          rx_steady   = 1'b0;
  bit          rx_hold     = 1'b0;

  rssi_trend_tracker DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int clamp_int(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Applies one observation to the model and returns the verdict it yields.
  function automatic verdict_t track_observation(logic [47:0] addr, logic [7:0] lvl_raw);
    verdict_t        v;
    int              lvl, r, gap, sm, mv, near_i, far_i, span, clo, conf, below;
    rtt_pkg::trend_e cand;
    v = '0;
    v.trend = rtt_pkg::TR_STEADY;
    lvl = $signed(lvl_raw);
    near_i = $signed(near_cfg);
    far_i = $signed(far_cfg);
    if (tgt_en && addr == tgt_addr) begin
      v.hit = 1'b1;
      r = lvl * 256;
      if (sample_cnt == 0) begin
        avg_fast = r;
        avg_slow = r;
      end else begin
        avg_fast += (r - avg_fast) >>> 2;
        avg_slow += (r - avg_slow) >>> 4;
      end
      last_dbm = lvl;
      if (lvl > peak_dbm) peak_dbm = lvl;
      if (sample_cnt < int'(rtt_pkg::CountMax)) sample_cnt++;
      gap = (avg_fast - avg_slow) / 256;
      sm = avg_fast / 256;
      mv = int'(move_cfg);
      if (sm >= near_i - 6 && gap > -mv) cand = rtt_pkg::TR_HERE;
      else if (gap >= mv) cand = rtt_pkg::TR_WARMER;
      else if (gap <= -mv) cand = rtt_pkg::TR_COLDER;
      else cand = rtt_pkg::TR_STEADY;
      if (cand == trend_now) begin
        trend_next = cand;
        pending_len = 0;
      end else if (cand == trend_next) begin
        if (pending_len < int'(rtt_pkg::RunMax)) pending_len++;
        if (cand == rtt_pkg::TR_STEADY || pending_len >= int'(confirm_cfg)) begin
          trend_now = cand;
          pending_len = 0;
        end
      end else begin
        trend_next = cand;
        pending_len = 1;
        if (cand == rtt_pkg::TR_STEADY) trend_now = rtt_pkg::TR_STEADY;
      end
    end
    if (sample_cnt == 0) begin
      v.listening = 1'b1;
      return v;
    end
    sm = avg_fast / 256;
    span = near_i - far_i;
    clo = 0;
    if (span > 0) clo = clamp_int(((sm - far_i) * 100) / span, 0, 100);
    conf = (sample_cnt < 40) ? sample_cnt * 100 / 40 : 100;
    below = peak_dbm - sm;
    if (below > 12) conf -= clamp_int((below - 12) * 3, 0, 40);
    conf = clamp_int(conf, 0, 100);
    v.trend          = trend_now;
    v.level_now      = 8'(last_dbm);
    v.level_smoothed = 8'(clamp_int(sm, -128, 0));
    v.level_peak     = 8'(peak_dbm);
    v.sample_total   = 16'(sample_cnt);
    v.closeness      = 7'(clo);
    v.confidence     = 7'(conf);
    v.locked         = (sample_cnt >= 8);
    return v;
  endfunction

  function automatic string fmt_verdict(verdict_t v);
    return $sformatf({"hit=%0d lst=%0d trend=%0d now=%0d avg=%0d peak=%0d n=%0d",
                      " close=%0d conf=%0d lock=%0d"},
                     v.hit, v.listening, v.trend, $signed(v.level_now),
                     $signed(v.level_smoothed), $signed(v.level_peak), v.sample_total,
                     v.closeness, v.confidence, v.locked);
  endfunction

  task automatic note_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_verdict(verdict_t got);
    verdict_t want;
    string    bad;
    verdict_cnt++;
    if (verdict_q.size() == 0) begin
      note_error($sformatf("verdict with nothing pending: %s", fmt_verdict(got)));
      return;
    end
    want = verdict_q.pop_front();
    bad = "";
    if (got.hit !== want.hit)                       bad = {bad, " hit"};
    if (got.listening !== want.listening)           bad = {bad, " listening"};
    if (got.trend !== want.trend)                   bad = {bad, " trend"};
    if (got.level_now !== want.level_now)           bad = {bad, " level_now"};
    if (got.level_smoothed !== want.level_smoothed) bad = {bad, " level_smoothed"};
    if (got.level_peak !== want.level_peak)         bad = {bad, " level_peak"};
    if (got.sample_total !== want.sample_total)     bad = {bad, " sample_total"};
    if (got.closeness !== want.closeness)           bad = {bad, " closeness"};
    if (got.confidence !== want.confidence)         bad = {bad, " confidence"};
    if (got.locked !== want.locked)                 bad = {bad, " locked"};
    if (bad != "")
      note_error($sformatf("verdict %0d differs in%s\n  expected %s\n  actual   %s",
                           verdict_cnt, bad, fmt_verdict(want), fmt_verdict(got)));
  endtask

  // Waits until every verdict in flight has been taken.
  task automatic wait_drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [rtt_pkg::CfgIdxW-1:0] idx, logic [47:0] val);
    wait_drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      rtt_pkg::CFG_TARGET_ADDRESS: tgt_addr    = val;
      rtt_pkg::CFG_TARGET_VALID:   tgt_en      = val[0];
      rtt_pkg::CFG_RSSI_NEAR:      near_cfg    = val[7:0];
      rtt_pkg::CFG_RSSI_FAR:       far_cfg     = val[7:0];
      rtt_pkg::CFG_MOVE_THRESHOLD: move_cfg    = val[4:0];
      rtt_pkg::CFG_CONFIRM_COUNT:  confirm_cfg = val[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_obs(logic [47:0] addr, logic [7:0] lvl, bit typed, verdict_t want);
    int unsigned gap;
    verdict_t    pred;
    if ($urandom_range(0, 49) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 19);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {lvl, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = track_observation(addr, lvl);
    verdict_q.push_back(typed ? want : pred);
    obs_sent++;
    if (pred.hit) hit_cnt++;
  endtask

  function automatic stim_row_t obs_row(logic [47:0] a, logic [7:0] l);
    stim_row_t r;
    r.kind = ROW_OBS;
    r.idx = '0;
    r.word = a;
    r.level = l;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [rtt_pkg::CfgIdxW-1:0] i, logic [47:0] d);
    stim_row_t r;
    r = obs_row(d, 8'h00);
    r.kind = ROW_CFG;
    r.idx = i;
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic [47:0] a, logic [7:0] l, verdict_t w);
    stim_row_t r;
    r = obs_row(a, l);
    r.typed = 1'b1;
    r.want = w;
    return r;
  endfunction

  function automatic logic [7:0] rand_dbm();
    return 8'(0 - int'($urandom_range(0, 128)));
  endfunction

  // sink: random stalls, plus the long hold-off
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 49) == 0) rx_steady = !rx_steady;
      stall = rx_steady ? 0 : $urandom_range(0, 19);
      @(negedge clk_i);
      if (stall > 0 || rx_hold) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
        while (rx_hold) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // hold the sink off while the source keeps pushing, so the block backs up
  initial begin
    wait (obs_sent >= 400);
    rx_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_verdict(verdict_t'(m_axis_tdata));
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= MaxCycles) begin
      $display("Timeout after %0d cycles, %0d verdicts still pending", cycle_cnt,
               verdict_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    verdict_t    idle_v, first_v;
    logic [47:0] t_addr, addr;
    logic [7:0]  t_near, t_far, lvl;
    logic [4:0]  t_move;
    logic [3:0]  t_conf;
    bit          t_en;
    int          walk, drift, seg_left, sel;
    int unsigned n_items;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;

    idle_v = '0;
    idle_v.listening = 1'b1;
    idle_v.trend = rtt_pkg::TR_STEADY;
    // first sample at +127 with the default settings
    first_v = '0;
    first_v.hit = 1'b1;
    first_v.trend = rtt_pkg::TR_STEADY;
    first_v.level_now = 8'h7F;
    first_v.level_peak = 8'h7F;
    first_v.sample_total = 16'd1;
    first_v.closeness = 7'd100;
    first_v.confidence = 7'd2;

    // no target selected yet
    dir_rows.push_back(typed_row(48'h0, 8'h00, idle_v));
    dir_rows.push_back(typed_row(AllOnes, 8'h80, idle_v));
    dir_rows.push_back(cfg_row(rtt_pkg::CFG_TARGET_ADDRESS, AllOnes));
    dir_rows.push_back(cfg_row(rtt_pkg::CFG_TARGET_VALID, 48'd1));
    // address mismatches while nothing sampled
    dir_rows.push_back(typed_row(48'h0, 8'h7F, idle_v));
    dir_rows.push_back(typed_row(48'h7FFF_FFFF_FFFF, 8'h80, idle_v));
    dir_rows.push_back(typed_row(AllOnes, 8'h7F, first_v));
    repeat (5) dir_rows.push_back(obs_row(AllOnes, 8'h80));
    dir_rows.push_back(cfg_row(rtt_pkg::CFG_CONFIRM_COUNT, 48'd1));
    dir_rows.push_back(cfg_row(rtt_pkg::CFG_MOVE_THRESHOLD, 48'd0));
    repeat (3) dir_rows.push_back(obs_row(AllOnes, 8'h7F));
    // near below far, then near equal to far: closeness stays 0
    dir_rows.push_back(cfg_row(rtt_pkg::CFG_RSSI_NEAR, 48'h9C));
    dir_rows.push_back(cfg_row(rtt_pkg::CFG_RSSI_FAR, 48'hD8));
    dir_rows.push_back(obs_row(AllOnes, 8'hC0));
    dir_rows.push_back(obs_row(AllOnes, 8'hD8));
    dir_rows.push_back(cfg_row(rtt_pkg::CFG_RSSI_NEAR, 48'h80));
    dir_rows.push_back(cfg_row(rtt_pkg::CFG_RSSI_FAR, 48'h80));
    dir_rows.push_back(obs_row(AllOnes, 8'hA0));
    dir_rows.push_back(cfg_row(rtt_pkg::CFG_RSSI_NEAR, 48'h00));
    dir_rows.push_back(cfg_row(rtt_pkg::CFG_MOVE_THRESHOLD, 48'd31));
    dir_rows.push_back(cfg_row(rtt_pkg::CFG_CONFIRM_COUNT, 48'd15));
    dir_rows.push_back(obs_row(AllOnes, 8'h00));
    dir_rows.push_back(obs_row(AllOnes, 8'h01));
    dir_rows.push_back(obs_row(AllOnes, 8'hFF));
    // zero confirm count behaves like one
    dir_rows.push_back(cfg_row(rtt_pkg::CFG_CONFIRM_COUNT, 48'd0));
    dir_rows.push_back(cfg_row(rtt_pkg::CFG_MOVE_THRESHOLD, 48'd1));
    repeat (2) dir_rows.push_back(obs_row(AllOnes, 8'h80));
    repeat (2) dir_rows.push_back(obs_row(AllOnes, 8'h7F));
    // target dropped: state must hold
    dir_rows.push_back(cfg_row(rtt_pkg::CFG_TARGET_VALID, 48'd0));
    dir_rows.push_back(obs_row(AllOnes, 8'h10));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) cfg_write(dir_rows[i].idx, dir_rows[i].word);
      else send_obs(dir_rows[i].word, dir_rows[i].level, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      t_addr = {16'($urandom), $urandom};
      t_en   = 1'b1;
      t_near = rand_dbm();
      t_far  = rand_dbm();
      t_move = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) :
                                             5'($urandom_range(0, 4));
      t_conf = 4'($urandom_range(1, 15));
      case (ph)
        0: begin
          t_addr = '0;
          t_near = 8'h00;
          t_far  = 8'h80;
          t_move = 5'd0;
          t_conf = 4'd1;
        end
        1: begin
          t_addr = AllOnes;
          t_near = 8'h80;
          t_far  = 8'h00;
          t_move = 5'd31;
          t_conf = 4'd15;
        end
        2: t_en = 1'b0;
        default: ;
      endcase
      cfg_write(rtt_pkg::CFG_TARGET_ADDRESS, t_addr);
      cfg_write(rtt_pkg::CFG_TARGET_VALID, 48'(t_en));
      cfg_write(rtt_pkg::CFG_RSSI_NEAR, 48'(t_near));
      cfg_write(rtt_pkg::CFG_RSSI_FAR, 48'(t_far));
      cfg_write(rtt_pkg::CFG_MOVE_THRESHOLD, 48'(t_move));
      cfg_write(rtt_pkg::CFG_CONFIRM_COUNT, 48'(t_conf));
      phase_cnt++;

      n_items = (ph == 2) ? 50 : 250;
      walk = int'($urandom_range(0, 255)) - 128;
      seg_left = 0;
      drift = 0;
      repeat (n_items) begin
        // level follows a drifting walk so trends build up and get confirmed
        if (seg_left == 0) begin
          drift = int'($urandom_range(0, 4)) - 2;
          seg_left = $urandom_range(10, 60);
        end
        seg_left--;
        sel = $urandom_range(0, 99);
        if (sel < 72) begin
          if ($urandom_range(0, 24) == 0) walk = int'($urandom_range(0, 255)) - 128;
          else walk = clamp_int(walk + drift + int'($urandom_range(0, 4)) - 2, -128, 127);
          addr = t_addr;
          lvl = 8'(walk);
        end else if (sel < 86) begin
          addr = t_addr ^ (48'd1 << $urandom_range(0, 47));
          lvl = 8'($urandom);
        end else begin
          addr = {16'($urandom), $urandom};
          lvl = 8'($urandom);
        end
        send_obs(addr, lvl, 1'b0, '0);
      end
    end

    wait_drain();
    repeat (TailCycles) @(posedge clk_i);
    $display("Covered %0d observations (%0d updated the tracker) over %0d setting phases",
             obs_sent, hit_cnt, phase_cnt);
    $display("%0d verdicts checked, %0d mismatches, %0d cycles", verdict_cnt, err_cnt,
             cycle_cnt);
    if (err_cnt == 0 && verdict_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
